@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define CHK_IMPL(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// same with no reset disable
`define CHK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

@@ rtl/lobm_pkg.sv @@
// Package: constants and types for the order book matcher
package lobm_pkg;
  localparam int unsigned TICKERS_DEF = 64;
  localparam int unsigned SLOTS_DEF = 64;
  localparam int unsigned TICKER_W = 6;
  localparam int unsigned QTY_W = 16;
  localparam int unsigned PRICE_W = 20;
  localparam int unsigned ID_W = 32;

  localparam logic [1:0] ST_ADDED = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_TRADE = 2'd2;
  localparam logic [1:0] ST_NONE = 2'd3;

  localparam logic ACT_ADD = 1'b0;
  localparam logic SIDE_BUY = 1'b0;

  typedef struct packed {
    logic [QTY_W-1:0] qty;
    logic [PRICE_W-1:0] price;
    logic [ID_W-1:0] id;
    logic live;
  } slot_t;
endpackage

@@ rtl/lobm_slot_mem.sv @@
// Slot store for one book side bank: one write port, one registered read port
module lobm_slot_mem #(
  parameter int unsigned DEPTH = 2,
  parameter int unsigned AW = 1
) (
  input  logic clk,
  input  logic we,
  input  logic [AW-1:0] waddr,
  input  lobm_pkg::slot_t wdata,
  input  logic [AW-1:0] raddr,
  output lobm_pkg::slot_t rdata
);
  import lobm_pkg::*;
  slot_t mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/limit_order_book_matcher_unit.sv @@
// Top level: order book matcher with per-side slot memories and scan sequencer
// Add: the fill count is read (S_ADD_RD), then the slot written and result registered (S_ADD_WR).
// Match: S_M_RD, S_SCAN (skipped for an out-of-range ticker), then S_DECIDE registers the result;
// both sides scanned in parallel, one slot per cycle per side; traded slots written back as
// result loads. The next input can transfer in the cycle after the result transfer.
// Reset: clears control and next id, then a sweep over all tickers zeroes fill counts (input held).
`include "assert_macros.svh"
module limit_order_book_matcher_unit #(
  parameter int unsigned TICKERS = lobm_pkg::TICKERS_DEF,
  parameter int unsigned SLOTS = lobm_pkg::SLOTS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic action,
  input  logic side,
  input  logic [lobm_pkg::TICKER_W-1:0] ticker,
  input  logic [lobm_pkg::QTY_W-1:0] quantity,
  input  logic [lobm_pkg::PRICE_W-1:0] limit_price,
  output logic out_valid,
  input  logic out_ready,
  output logic [1:0] status,
  output logic [lobm_pkg::ID_W-1:0] assigned_id,
  output logic [lobm_pkg::QTY_W-1:0] trade_quantity,
  output logic [lobm_pkg::PRICE_W-1:0] trade_price,
  output logic [lobm_pkg::ID_W-1:0] buyer_id,
  output logic [lobm_pkg::ID_W-1:0] seller_id
);
  import lobm_pkg::*;

  localparam int unsigned TW = (TICKERS > 1) ? $clog2(TICKERS) : 1;
  localparam int unsigned SW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned AW = TW + SW;
  // each ticker owns a power-of-two block of slot addresses
  localparam int unsigned DEPTH = TICKERS * (2 ** SW);

  typedef enum logic [3:0] {
    S_IDLE, S_ADD_RD, S_ADD_WR, S_M_RD, S_SCAN, S_DECIDE, S_OUT
  } state_t;

  state_t state;

  // fill counts: one memory per side, indexed by ticker (registered read, like the slot memories)
  logic [CW-1:0] fill_buy [TICKERS];
  logic [CW-1:0] fill_sell [TICKERS];
  logic [CW-1:0] fb_q, fs_q;
  logic fill_we_b, fill_we_s;
  logic [CW-1:0] fill_wdata;
  // reset clears fill counts by a sweep over tickers
  logic [TW-1:0] clr_idx;
  logic clearing;

  // input item latch
  logic side_q;
  logic [TW-1:0] tick_q;
  logic tick_ok;
  logic [QTY_W-1:0] qty_q;
  logic [PRICE_W-1:0] price_q;
  logic [ID_W-1:0] next_id, id_q;

  // slot memories, one per side
  logic we_b, we_s;
  logic [AW-1:0] wa_b, wa_s, ra_b, ra_s;
  slot_t wd_b, wd_s, rd_b, rd_s;

  lobm_slot_mem #(.DEPTH(DEPTH), .AW(AW)) u_buy (
    .clk(clk), .we(we_b), .waddr(wa_b), .wdata(wd_b), .raddr(ra_b), .rdata(rd_b));
  lobm_slot_mem #(.DEPTH(DEPTH), .AW(AW)) u_sell (
    .clk(clk), .we(we_s), .waddr(wa_s), .wdata(wd_s), .raddr(ra_s), .rdata(rd_s));

  // scan: address counter issues reads, data compare runs on the registered read data in the next cycle
  logic [CW-1:0] rcnt;      // next index to issue
  logic rv_b, rv_s;         // read data valid this cycle
  logic [SW-1:0] ridx;      // index of data arriving
  logic hb, hs;
  logic [SW-1:0] bi, si;
  slot_t bbest, sbest;

  always_ff @(posedge clk) begin
    fb_q <= fill_buy[tick_q];
    fs_q <= fill_sell[tick_q];
    if (fill_we_b) fill_buy[clearing ? clr_idx : tick_q] <= fill_wdata;
    if (fill_we_s) fill_sell[clearing ? clr_idx : tick_q] <= fill_wdata;
  end

  logic [QTY_W-1:0] tq;
  assign tq = (bbest.qty < sbest.qty) ? bbest.qty : sbest.qty;

  always_comb begin
    fill_we_b = 1'b0;
    fill_we_s = 1'b0;
    fill_wdata = '0;
    we_b = 1'b0;
    we_s = 1'b0;
    wa_b = {tick_q, SW'(fb_q)};
    wa_s = {tick_q, SW'(fs_q)};
    wd_b = '{qty: qty_q, price: price_q, id: id_q, live: 1'b1};
    wd_s = wd_b;
    ra_b = {tick_q, rcnt[SW-1:0]};
    ra_s = {tick_q, rcnt[SW-1:0]};
    if (clearing) begin
      fill_we_b = 1'b1;
      fill_we_s = 1'b1;
    end else if (state == S_ADD_WR && tick_ok) begin
      if (side_q == SIDE_BUY) begin
        if (fb_q < CW'(SLOTS)) begin
          we_b = 1'b1;
          fill_we_b = 1'b1;
          fill_wdata = fb_q + CW'(1);
        end
      end else if (fs_q < CW'(SLOTS)) begin
        we_s = 1'b1;
        fill_we_s = 1'b1;
        fill_wdata = fs_q + CW'(1);
      end
    end else if (state == S_DECIDE && hb && hs && bbest.price >= sbest.price) begin
      we_b = 1'b1;
      we_s = 1'b1;
      wa_b = {tick_q, bi};
      wa_s = {tick_q, si};
      wd_b = bbest;
      wd_b.qty = bbest.qty - tq;
      wd_b.live = (bbest.qty != tq);
      wd_s = sbest;
      wd_s.qty = sbest.qty - tq;
      wd_s.live = (sbest.qty != tq);
    end
  end

  assign in_ready = (state == S_IDLE) && !clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      clearing <= 1'b1;
      clr_idx <= '0;
      next_id <= '0;
      out_valid <= 1'b0;
      rv_b <= 1'b0;
      rv_s <= 1'b0;
    end else begin
      if (clearing) begin
        clr_idx <= clr_idx + TW'(1);
        if (32'(clr_idx) == TICKERS - 1) clearing <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            side_q <= side;
            tick_q <= TW'(ticker);
            tick_ok <= (32'(ticker) < TICKERS);
            qty_q <= quantity;
            price_q <= limit_price;
            id_q <= next_id;
            if (action == ACT_ADD) begin
              next_id <= next_id + ID_W'(1);
              state <= S_ADD_RD;
            end else state <= S_M_RD;
          end
        end
        S_ADD_RD: state <= S_ADD_WR;   // fill count read in flight
        S_ADD_WR: begin
          status <= (tick_ok && ((side_q == SIDE_BUY) ? fb_q < CW'(SLOTS)
                                                      : fs_q < CW'(SLOTS)))
                    ? ST_ADDED : ST_FULL;
          assigned_id <= id_q;
          trade_quantity <= '0;
          trade_price <= '0;
          buyer_id <= '0;
          seller_id <= '0;
          out_valid <= 1'b1;
          state <= S_OUT;
        end
        S_M_RD: begin
          rcnt <= '0;
          hb <= 1'b0;
          hs <= 1'b0;
          bi <= '0;
          si <= '0;
          state <= tick_ok ? S_SCAN : S_DECIDE;
        end
        S_SCAN: begin
          rv_b <= (rcnt < fb_q);
          rv_s <= (rcnt < fs_q);
          ridx <= rcnt[SW-1:0];
          if (rcnt < fb_q || rcnt < fs_q) rcnt <= rcnt + CW'(1);
          if (rv_b && rd_b.live && rd_b.qty != '0 && (!hb || rd_b.price > bbest.price)) begin
            hb <= 1'b1;
            bi <= ridx;
            bbest <= rd_b;
          end
          if (rv_s && rd_s.live && rd_s.qty != '0 && (!hs || rd_s.price < sbest.price)) begin
            hs <= 1'b1;
            si <= ridx;
            sbest <= rd_s;
          end
          if (!(rcnt < fb_q || rcnt < fs_q) && !rv_b && !rv_s) state <= S_DECIDE;
        end
        S_DECIDE: begin
          assigned_id <= '0;
          if (tick_ok && hb && hs && bbest.price >= sbest.price) begin
            status <= ST_TRADE;
            trade_quantity <= tq;
            trade_price <= sbest.price;
            buyer_id <= bbest.id;
            seller_id <= sbest.id;
          end else begin
            status <= ST_NONE;
            trade_quantity <= '0;
            trade_price <= '0;
            buyer_id <= '0;
            seller_id <= '0;
          end
          out_valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // no item is taken while a result is pending
  `CHK_IMPL(a_busy_out, clk, rst, out_valid |-> !in_ready, "ready while result pending")
  // an add result always carries zero trade fields
  `CHK_IMPL(a_add_clean, clk, rst,
    (out_valid && (status == ST_ADDED || status == ST_FULL)) |-> trade_quantity == '0,
    "add result with trade quantity")
  // a trade never reports zero shares
  `CHK_IMPL(a_trade_qty, clk, rst,
    (out_valid && status == ST_TRADE) |-> trade_quantity != '0, "empty trade")
endmodule

@@ sim/limit_order_book_matcher_unit_test.sv @@
// Testbench for the order book matcher: queue-fed driver, monitor and scoreboard
`timescale 1ns / 1ps
module limit_order_book_matcher_unit_test;
  import lobm_pkg::*;

  localparam int NT = TICKERS_DEF;
  localparam int NS = SLOTS_DEF;
  localparam int N_RAND = 1370;

  // one pending order request
  typedef struct packed {
    logic act;
    logic sd;
    logic [TICKER_W-1:0] tk;
    logic [QTY_W-1:0] qty;
    logic [PRICE_W-1:0] px;
  } order_req_t;

  // one book response
  typedef struct packed {
    logic [1:0] st;
    logic [ID_W-1:0] aid;
    logic [QTY_W-1:0] tq;
    logic [PRICE_W-1:0] tp;
    logic [ID_W-1:0] bid;
    logic [ID_W-1:0] sid;
  } book_resp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic action = 1'b0;
  logic side = 1'b0;
  logic [TICKER_W-1:0] ticker = '0;
  logic [QTY_W-1:0] quantity = '0;
  logic [PRICE_W-1:0] limit_price = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] status;
  logic [ID_W-1:0] assigned_id;
  logic [QTY_W-1:0] trade_quantity;
  logic [PRICE_W-1:0] trade_price;
  logic [ID_W-1:0] buyer_id;
  logic [ID_W-1:0] seller_id;

  limit_order_book_matcher_unit uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow book
  logic [ID_W-1:0] book_next_id;
  int unsigned book_fill [2*NT];
  logic [ID_W-1:0] book_id [2*NT*NS];
  logic [QTY_W-1:0] book_qty [2*NT*NS];
  logic [PRICE_W-1:0] book_px [2*NT*NS];
  bit book_live [2*NT*NS];

  order_req_t pending_orders [$];
  book_resp_t expected_resps [$];
  int errors = 0;
  int n_sent = 0;
  bit calm = 1'b0;      // last stretch: no new input gaps, output always ready
  bit stim_done = 1'b0;

  // next book response for a request, updating the shadow book
  function automatic book_resp_t apply_order(order_req_t r);
    book_resp_t o;
    int unsigned bs, a, bb, sb, bi, si;
    bit hb, hs;
    logic [QTY_W-1:0] tq;
    o = '0;
    if (r.act == ACT_ADD) begin
      o.aid = book_next_id;
      book_next_id = book_next_id + 1;
      bs = r.tk * 2 + r.sd;
      if (r.tk >= NT || book_fill[bs] >= NS) begin
        o.st = ST_FULL;
      end else begin
        a = bs * NS + book_fill[bs];
        book_id[a] = o.aid;
        book_qty[a] = r.qty;
        book_px[a] = r.px;
        book_live[a] = 1'b1;
        book_fill[bs]++;
        o.st = ST_ADDED;
      end
      return o;
    end
    o.st = ST_NONE;
    if (r.tk >= NT) return o;
    bb = r.tk * 2 * NS;
    sb = (r.tk * 2 + 1) * NS;
    hb = 0; hs = 0; bi = 0; si = 0;
    for (int i = 0; i < book_fill[r.tk*2]; i++)
      if (book_live[bb+i] && book_qty[bb+i] != 0 && (!hb || book_px[bb+i] > book_px[bi])) begin
        hb = 1; bi = bb + i;
      end
    for (int i = 0; i < book_fill[r.tk*2+1]; i++)
      if (book_live[sb+i] && book_qty[sb+i] != 0 && (!hs || book_px[sb+i] < book_px[si])) begin
        hs = 1; si = sb + i;
      end
    if (!hb || !hs || book_px[bi] < book_px[si]) return o;
    tq = (book_qty[bi] < book_qty[si]) ? book_qty[bi] : book_qty[si];
    book_qty[bi] -= tq;
    book_qty[si] -= tq;
    if (book_qty[bi] == 0) book_live[bi] = 1'b0;
    if (book_qty[si] == 0) book_live[si] = 1'b0;
    o.st = ST_TRADE;
    o.tq = tq;
    o.tp = book_px[si];
    o.bid = book_id[bi];
    o.sid = book_id[si];
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  task automatic queue_order(int act, int sd, int tk, int qty, int px);
    order_req_t r;
    r.act = act[0];
    r.sd = sd[0];
    r.tk = tk[TICKER_W-1:0];
    r.qty = qty[QTY_W-1:0];
    r.px = px[PRICE_W-1:0];
    pending_orders.push_back(r);
  endtask

  // in_ready as seen at the last rising edge
  bit in_ready_s = 1'b0;
  int out_gap = 0;

  // driver: idles in bursts, holds payload until transfer
  int in_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready_s) begin
        // transfer happened at the last rising edge
      end
      if (!in_valid || in_ready_s) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_orders.size() > 0) begin
          order_req_t r;
          r = pending_orders.pop_front();
          in_valid <= 1'b1;
          action <= r.act; side <= r.sd; ticker <= r.tk;
          quantity <= r.qty; limit_price <= r.px;
          expected_resps.push_back(apply_order(r));
          n_sent++;
          if (!calm && $urandom_range(0, 9) == 0) in_gap <= $urandom_range(1, 9);
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (calm) out_ready <= 1'b1;
      else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 7) == 0) out_gap <= $urandom_range(1, 9);
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    in_ready_s <= in_ready;
    if (!rst && out_valid && out_ready) begin
      if (expected_resps.size() == 0) begin
        report_mismatch("unexpected response", status, 0);
      end else begin
        book_resp_t e;
        e = expected_resps.pop_front();
        if (status !== e.st) report_mismatch("status", status, e.st);
        if (assigned_id !== e.aid) report_mismatch("assigned_id", assigned_id, e.aid);
        if (trade_quantity !== e.tq) report_mismatch("trade_quantity", trade_quantity, e.tq);
        if (trade_price !== e.tp) report_mismatch("trade_price", trade_price, e.tp);
        if (buyer_id !== e.bid) report_mismatch("buyer_id", buyer_id, e.bid);
        if (seller_id !== e.sid) report_mismatch("seller_id", seller_id, e.sid);
      end
    end
  end

  initial begin
    int tk;
    book_next_id = '0;
    foreach (book_fill[i]) book_fill[i] = 0;
    foreach (book_live[i]) book_live[i] = 1'b0;
    // directed: empty book, extremes, crossing, zero quantity, full side
    queue_order(1, 0, 0, 0, 0);
    queue_order(0, 0, 0, 16'hFFFF, 20'hFFFFF);
    queue_order(0, 1, 0, 100, 0);
    queue_order(1, 1, 0, 0, 0);
    queue_order(1, 0, 0, 0, 0);
    queue_order(0, 0, 63, 0, 500);
    queue_order(0, 1, 63, 10, 400);
    queue_order(1, 0, 63, 0, 0);
    queue_order(0, 0, 5, 20, 300);
    queue_order(0, 1, 5, 20, 301);
    queue_order(1, 0, 5, 0, 0);
    queue_order(0, 1, 5, 7, 300);
    queue_order(0, 1, 5, 9, 300);
    queue_order(1, 1, 5, 16'hFFFF, 20'hFFFFF);
    queue_order(1, 0, 5, 0, 0);
    for (int i = 0; i < NS + 2; i++) queue_order(0, 1, 9, $urandom_range(1, 50), $urandom);
    queue_order(0, 0, 9, 16'hFFFF, 20'hFFFFF);
    queue_order(1, 0, 9, 0, 0);
    // random: a few busy tickers, mostly adds and matches around a mid price
    for (int i = 0; i < N_RAND; i++) begin
      tk = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(10, 13);
      if ($urandom_range(0, 2) == 0)
        queue_order(1, $urandom, tk, $urandom, $urandom);
      else if ($urandom_range(0, 9) == 0)
        queue_order(0, $urandom, tk, $urandom, $urandom);
      else
        queue_order(0, $urandom, tk, $urandom_range(0, 300),
                    20'h80000 + $urandom_range(0, 64) - 32);
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    wait (pending_orders.size() < 200);
    calm = 1'b1;
    wait (pending_orders.size() == 0 && expected_resps.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("** limit_order_book_matcher_unit: PASSED **");
    else $display("** limit_order_book_matcher_unit: FAILED **");
    $finish;
  end

  // worst case per item ~ scan of two sides plus stall gaps
  initial begin
    #20ms;
    $display("** limit_order_book_matcher_unit: FAILED **");
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+rtl
rtl/lobm_pkg.sv
rtl/lobm_slot_mem.sv
rtl/limit_order_book_matcher_unit.sv
sim/limit_order_book_matcher_unit_test.sv
